// ===== rtl/oets_pkg.sv =====
// Shared types and constants of the odd-even transposition sorter.
`default_nettype none
package oets_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // write the incoming word at the fill index
    logic swap;   // run one compare-exchange phase
    logic odd;    // phase parity: pairs (1,2),(3,4)... when set
    logic shift;  // move every entry down by one
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/oets_dp.sv =====
// Element store with parallel compare-exchange lanes and an emit shift path.
`default_nettype none
module oets_dp import oets_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned IDXW  = $clog2(DEPTH),
  parameter int unsigned CNTW  = $clog2(DEPTH + 1)
) (
  input  wire                       clk_i,
  input  dp_cmd_t                   cmd_i,
  input  wire        [IDXW-1:0]     wr_idx_i,
  input  wire        [CNTW-1:0]     count_i,
  input  wire signed [DATA_W-1:0]   value_i,
  output logic signed [DATA_W-1:0]  head_o
);

  logic signed [DATA_W-1:0] store_q [DEPTH];
  logic signed [DATA_W-1:0] store_d [DEPTH];

  always_comb begin
    store_d = store_q;
    if (cmd_i.load) begin
      store_d[wr_idx_i] = value_i;
    end else if (cmd_i.swap) begin
      // Pairs are disjoint, so every lane works on its own two entries.
      for (int k = 0; k < int'(DEPTH) - 1; k++) begin
        if ((k[0] == cmd_i.odd) && (CNTW'(k + 1) < count_i) &&
            (store_q[k] > store_q[k+1])) begin
          store_d[k]   = store_q[k+1];
          store_d[k+1] = store_q[k];
        end
      end
    end else if (cmd_i.shift) begin
      for (int k = 0; k < int'(DEPTH) - 1; k++) begin
        store_d[k] = store_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  assign head_o = store_q[0];

endmodule
`default_nettype wire

// ===== rtl/oets_ctrl.sv =====
// Load, sort and emit sequencer of the odd-even transposition sorter.
`default_nettype none
module oets_ctrl import oets_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned IDXW  = $clog2(DEPTH),
  parameter int unsigned CNTW  = $clog2(DEPTH + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               end_of_set_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              final_result_o,
  output logic              overflow_o,
  output dp_cmd_t           cmd_o,
  output logic [IDXW-1:0]   wr_idx_o,
  output logic [CNTW-1:0]   count_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [IDXW-1:0] step_q, step_d;
  logic            drop_q, drop_d;
  logic            in_acc, out_acc, last_step;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign last_step = (CNTW'(step_q) == (cnt_q - CNTW'(1)));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    drop_d     = drop_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_LOAD);
    out_valid_o = (state_q == ST_EMIT);
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CNTW'(DEPTH)) begin
            cmd_o.load = 1'b1;
            cnt_d      = cnt_q + CNTW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (end_of_set_i) begin
            state_d = ST_SORT;
            step_d  = '0;
          end
        end
      end
      ST_SORT: begin
        cmd_o.swap = 1'b1;
        cmd_o.odd  = step_q[0];
        step_d     = step_q + IDXW'(1);
        if (last_step) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          cmd_o.shift = 1'b1;
          step_d      = step_q + IDXW'(1);
          if (last_step) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
            drop_d  = 1'b0;
            step_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      step_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      drop_q  <= drop_d;
    end
  end

  assign wr_idx_o       = cnt_q[IDXW-1:0];
  assign count_o        = cnt_q;
  assign final_result_o = last_step;
  assign overflow_o     = drop_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("fill count beyond capacity");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (!cmd_o.swap && !cmd_o.shift))
    else $error("store reordered while loading");

  a_eos_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_set_i) |=> (state_q == ST_SORT) && (cnt_q != '0))
    else $error("end of set did not start a non-empty sort");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && final_result_o) |=> (state_q == ST_LOAD) && (cnt_q == '0) && !drop_q)
    else $error("batch state not cleared after final word");

endmodule
`default_nettype wire

// ===== rtl/odd_even_transposition_sort.sv =====
// Top level of the odd-even transposition sorter: controller plus datapath.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | value_i, end_of_set_i
//  out     | out_valid_o/out_stall_i | sorted_value_o, final_result_o, overflow_o
//
// Load takes one word per cycle into the next free store entry.
// A batch of n words then runs n phases in sort, one compare-exchange phase
// per cycle across up to DEPTH/2 parallel lanes, and then emits, one word per
// cycle off the head of the store while out_stall_i is low.
// Input stalls from the end-of-set word until the final sorted word is taken.
// Reset clears the fill count, the drop flag and the sequencer; the store holds no reset.
`default_nettype none
module odd_even_transposition_sort import oets_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire signed [DATA_W-1:0]   value_i,
  input  wire                       end_of_set_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic signed [DATA_W-1:0]  sorted_value_o,
  output logic                      final_result_o,
  output logic                      overflow_o
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  dp_cmd_t         cmd;
  logic [IDXW-1:0] wr_idx;
  logic [CNTW-1:0] count;

  // Sequence the batch: fill, n phases, then drain head first.
  oets_ctrl #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW),
    .CNTW  (CNTW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .end_of_set_i   (end_of_set_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .final_result_o (final_result_o),
    .overflow_o     (overflow_o),
    .cmd_o          (cmd),
    .wr_idx_o       (wr_idx),
    .count_o        (count)
  );

  // Hold the words; the head entry is the outgoing word and holds while stalled.
  oets_dp #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW),
    .CNTW  (CNTW)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .wr_idx_i (wr_idx),
    .count_i  (count),
    .value_i  (value_i),
    .head_o   (sorted_value_o)
  );

endmodule
`default_nettype wire

// ===== test/sort_scoreboard.sv =====
// Scoreboard package for the odd-even transposition sorter: set predictor and word check.
package sort_check_pkg;
  import oets_pkg::*;

  localparam int unsigned SET_CAP    = DEPTH_DEFAULT;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    logic signed [DATA_W-1:0] word;
    logic                     is_last;
    logic                     dropped;
  } sorted_word_t;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] held [SET_CAP];
    int unsigned              fill;
    bit                       dropped;
    sorted_word_t             ascending_q [$];
    int unsigned              mismatches;
    int unsigned              words_in;
    int unsigned              words_out;
    int unsigned              sets_done;
    int unsigned              sets_dropped;

    function new();
      fill         = 0;
      dropped      = 1'b0;
      mismatches   = 0;
      words_in     = 0;
      words_out    = 0;
      sets_done    = 0;
      sets_dropped = 0;
    endfunction

    // Take one accepted input word; on the end mark, sort the set and queue its words.
    function void note_element(logic signed [DATA_W-1:0] word, logic is_last);
      sorted_word_t             w;
      logic signed [DATA_W-1:0] tmp;
      int unsigned              phase;
      int unsigned              k;
      words_in++;
      if (fill < SET_CAP) begin
        held[fill] = word;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      // One compare-exchange phase per held word, alternating pair parity.
      for (phase = 0; phase < fill; phase++) begin
        for (k = phase % 2; k + 1 < fill; k += 2) begin
          if (held[k] > held[k+1]) begin
            tmp         = held[k];
            held[k]     = held[k+1];
            held[k+1]   = tmp;
          end
        end
      end
      for (k = 0; k < fill; k++) begin
        w.word    = held[k];
        w.is_last = (k + 1 == fill);
        w.dropped = dropped;
        ascending_q.insert(ascending_q.size(), w);
      end
      sets_done++;
      if (dropped) sets_dropped++;
      fill    = 0;
      dropped = 1'b0;
    endfunction

    // Compare one accepted output word against the oldest queued word.
    function void check_word(logic signed [DATA_W-1:0] word, logic is_last, logic ovf);
      sorted_word_t exp_w;
      words_out++;
      if (ascending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected word: value %0d last %0b overflow %0b", word, is_last, ovf);
        end
        return;
      end
      exp_w = ascending_q.pop_front();
      if (exp_w.word !== word || exp_w.is_last !== is_last || exp_w.dropped !== ovf) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display({"mismatch: expected value %0d last %0b overflow %0b, ",
                    "got value %0d last %0b overflow %0b"},
                   exp_w.word, exp_w.is_last, exp_w.dropped, word, is_last, ovf);
        end
      end
    endfunction

    function int unsigned pending();
      return ascending_q.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Testbench top: directed and random sets through the sorter, each output word checked.
module tb_top;
  import oets_pkg::*;
  import sort_check_pkg::*;

  localparam int unsigned ITEM_TARGET    = 460;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 4 * SET_CAP + 64;
  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value        = '0;
  logic                     end_of_set   = 1'b0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_result;
  logic                     overflow;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  sort_scoreboard sb;

  odd_even_transposition_sort u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_i        (value),
    .end_of_set_i   (end_of_set),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sorted_value_o (sorted_value),
    .final_result_o (final_result),
    .overflow_o     (overflow)
  );

  always #10 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Set lengths: mostly within the store, some exactly full, some past it.
  function automatic int unsigned pick_set_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, SET_CAP);
      6:                return SET_CAP;
      7:                return $urandom_range(1, 2);
      default:          return $urandom_range(SET_CAP + 1, SET_CAP + 5);
    endcase
  endfunction

  // Full-range words, small words that repeat often, and both extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 8) - 4;
      6:          return MOST_NEG;
      default:    return MOST_POS;
    endcase
  endfunction

  // Drop valid and scramble the idle payload while the input idles.
  task automatic idle_input(input int unsigned n);
    if (n != 0) begin
      in_valid   <= 1'b0;
      value      <= $urandom;
      end_of_set <= $urandom_range(0, 1);
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one word and hold it until the sorter takes it.
  task automatic send_element(input logic signed [DATA_W-1:0] word, input logic is_last);
    in_valid   <= 1'b1;
    value      <= word;
    end_of_set <= is_last;
    do @(posedge clk); while (in_stall);
    sb.note_element(word, is_last);
  endtask

  // Feed a whole set, end mark on its final word; some sets go back to back.
  task automatic send_set(input logic signed [DATA_W-1:0] words [$]);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    foreach (words[i]) begin
      send_element(words[i], i == words.size() - 1);
      if (!steady) idle_input(pick_gap());
    end
    if (!steady) idle_input(pick_gap());
  endtask

  // Output stall: open runs of varied length, some very long, then stalls.
  initial begin : out_stall_gen
    int unsigned run_len;
    int unsigned stall_len;
    int unsigned r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70) run_len = $urandom_range(1, 6);
      else if (r < 90) run_len = $urandom_range(7, 30);
      else run_len = $urandom_range(60, 200);
      stall_len = pick_gap();
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Check every word the sorter hands over.
  always @(posedge clk) begin
    if (rst_n && out_fire) sb.check_word(sorted_value, final_result, overflow);
  end

  // End the run if neither side moves a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic signed [DATA_W-1:0] set_q [$];
    int unsigned              set_len;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single word at the negative extreme, then both extremes reversed.
    set_q = {MOST_NEG};
    send_set(set_q);
    set_q = {MOST_POS, MOST_NEG};
    send_set(set_q);
    // Duplicates must keep their place around a smaller word.
    set_q = {32'sd7, -32'sd7, 32'sd7};
    send_set(set_q);
    // One past capacity: the end-marked word is dropped, the set still emits.
    set_q = {};
    for (int i = 0; i < SET_CAP + 1; i++) set_q.insert(set_q.size(), 1000 - 37 * i);
    set_q[0] = MOST_POS;
    set_q[5] = MOST_NEG;
    send_set(set_q);

    while (sb.words_in < ITEM_TARGET) begin
      set_q   = {};
      set_len = pick_set_len();
      repeat (set_len) set_q.insert(set_q.size(), pick_value());
      send_set(set_q);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d words in %0d sets, %0d of them overflowing the %0d-entry store.",
             sb.words_in, sb.sets_done, sb.sets_dropped, SET_CAP);
    $display("Checked %0d sorted words, %0d failed.", sb.words_out, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
